>>> hdl/ffa_pkg.sv
// Shared types, codes and constants for the first-fit allocator.
package ffa_pkg;

  localparam int AW              = 16;
  localparam int EW              = AW + 1;
  localparam int MAX_BLOCKS_DEF  = 16;
  localparam int MAX_WAITING_DEF = 16;
  localparam logic [AW-1:0] MEM_SIZE_RST = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_TERM  = 2'd2,
    CMD_HALT  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    K_PLACED = 3'd0,
    K_AFAIL  = 3'd1,
    K_OK     = 3'd2,
    K_FAIL   = 3'd3,
    K_HALT   = 3'd4
  } kind_t;

  typedef struct packed {
    logic [1:0]    cmd;
    logic [AW-1:0] process_id;
    logic [AW-1:0] req_size;
    logic [AW-1:0] block_addr;
  } in_item_t;

  typedef struct packed {
    logic [AW-1:0] request_id;
    logic [2:0]    result_kind;
    logic [AW-1:0] placed_addr;
    logic          last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_FF, ST_A_PLACE, ST_F_SCAN, ST_F_LO, ST_F_HI,
    ST_F_PACK, ST_T_RMB, ST_T_WQ, ST_T_RETRY, ST_T_PLACE, ST_H_LOOP, ST_FINAL
  } state_t;

  typedef enum logic [1:0] {INS_REQ, INS_WAIT_PE, INS_WAIT_LO} ins_sel_t;
  typedef enum logic [1:0] {AS_ZERO, AS_PE, AS_LO} addr_sel_t;
  typedef enum logic [1:0] {RD_K, RD_KM1, RD_KP1} rd_sel_t;

  typedef struct packed {
    logic      latch;
    logic      k_clr;
    logic      k_inc;
    logic      pe_clr;
    logic      pe_upd;
    logic      lo_ld;
    logic      hi_ld;
    logic      rm_blk;
    logic      ins;
    ins_sel_t  ins_sel;
    logic      pack_adv;
    logic      push_wait;
    logic      rm_wait;
    logic      i_clr;
    logic      i_inc;
    logic      wq_clr;
    logic      got_set;
    logic      final_ld;
    kind_t     final_kind;
    logic      emit;
    logic      emit_final;
    logic      emit_wid;
    kind_t     emit_kind;
    addr_sel_t emit_addr;
    logic      emit_last;
    rd_sel_t   rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic k_end;
    logic k_zero;
    logic kp1_end;
    logic i_end;
    logic tbl_full;
    logic wq_full;
    logic size_bad;
    logic fit_here;
    logic tail_fit;
    logic start_hit;
    logic own_hit;
    logic wfits;
    logic wpid_hit;
    logic got;
    logic can_emit;
  } dp_sts_t;

endpackage

>>> hdl/ffa_dp.sv
// Datapath: block table, wait queue, scan registers and result register.
module ffa_dp #(
  parameter int MAX_BLOCKS  = ffa_pkg::MAX_BLOCKS_DEF,
  parameter int MAX_WAITING = ffa_pkg::MAX_WAITING_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ffa_pkg::in_item_t  in_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  ffa_pkg::dp_cmd_t   cmd,
  output ffa_pkg::dp_sts_t   sts,
  input  logic               out_stall,
  output logic               out_valid,
  output ffa_pkg::out_item_t out_data
);
  import ffa_pkg::*;

  localparam int BW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int BCW = $clog2(MAX_BLOCKS + 1);
  localparam int WW  = (MAX_WAITING > 1) ? $clog2(MAX_WAITING) : 1;
  localparam int WCW = $clog2(MAX_WAITING + 1);

  in_item_t      req_r;
  logic [AW-1:0] id_r, ctr_r, mem_r;
  logic [BCW-1:0] blk_cnt_r, blk_cnt_nxt, k_r, k_nxt;
  logic [WCW-1:0] wcnt_r, wcnt_nxt, i_r, i_nxt;
  logic [EW-1:0] pe_r, pe_nxt, lo_r, lo_nxt, room_r, room_nxt;
  logic          got_r;
  kind_t         fin_kind_r;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  logic [AW-1:0] ts_r [MAX_BLOCKS], ts_nxt [MAX_BLOCKS];
  logic [AW-1:0] tl_r [MAX_BLOCKS], tl_nxt [MAX_BLOCKS];
  logic [AW-1:0] to_r [MAX_BLOCKS], to_nxt [MAX_BLOCKS];
  logic [AW-1:0] wid_r [MAX_WAITING], wid_nxt [MAX_WAITING];
  logic [AW-1:0] wpid_r [MAX_WAITING], wpid_nxt [MAX_WAITING];
  logic [AW-1:0] wsz_r [MAX_WAITING], wsz_nxt [MAX_WAITING];

  // single table read port
  logic [BCW-1:0] rd_idx;
  logic [AW-1:0]  rd_start, rd_len, rd_own;
  logic [EW-1:0]  rs, rd_end, mem_e, hi, ff_sz_e;
  logic [WW-1:0]  wi;
  logic [AW-1:0]  w_id, w_pid, w_sz, ff_sz;
  logic           can_emit;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_KM1:  rd_idx = k_r - BCW'(1);
      RD_KP1:  rd_idx = k_r + BCW'(1);
      default: rd_idx = k_r;
    endcase
  end

  assign rd_start = ts_r[rd_idx[BW-1:0]];
  assign rd_len   = tl_r[rd_idx[BW-1:0]];
  assign rd_own   = to_r[rd_idx[BW-1:0]];
  assign rs       = {1'b0, rd_start};
  assign rd_end   = rs + {1'b0, rd_len};
  assign mem_e    = {1'b0, mem_r};

  assign wi    = i_r[WW-1:0];
  assign w_id  = wid_r[wi];
  assign w_pid = wpid_r[wi];
  assign w_sz  = wsz_r[wi];
  assign ff_sz = (cmd_t'(req_r.cmd) == CMD_ALLOC) ? req_r.req_size : w_sz;
  assign ff_sz_e = {1'b0, ff_sz};

  assign can_emit = !out_valid_r || !out_stall;

  always_comb begin
    sts.cmd       = cmd_t'(req_r.cmd);
    sts.k_end     = (k_r >= blk_cnt_r);
    sts.k_zero    = (k_r == '0);
    sts.kp1_end   = (({1'b0, k_r} + (BCW+1)'(1)) >= {1'b0, blk_cnt_r});
    sts.i_end     = (i_r >= wcnt_r);
    sts.tbl_full  = (blk_cnt_r >= BCW'(MAX_BLOCKS));
    sts.wq_full   = (wcnt_r >= WCW'(MAX_WAITING));
    sts.size_bad  = (req_r.req_size == '0) || (req_r.req_size > mem_r);
    sts.fit_here  = (rs >= pe_r) && (rd_start <= mem_r) && ((rs - pe_r) >= ff_sz_e);
    sts.tail_fit  = (mem_e >= pe_r) && ((mem_e - pe_r) >= ff_sz_e);
    sts.start_hit = (rd_start == req_r.block_addr);
    sts.own_hit   = (rd_own == req_r.process_id);
    sts.wfits     = ({1'b0, w_sz} <= room_r);
    sts.wpid_hit  = (w_pid == req_r.process_id);
    sts.got       = got_r;
    sts.can_emit  = can_emit;
  end

  // insertion operands and sorted position
  logic [EW-1:0]  ins_addr;
  logic [AW-1:0]  ins_len, ins_own;
  logic [BCW-1:0] pos;

  always_comb begin
    unique case (cmd.ins_sel)
      INS_WAIT_PE: begin ins_addr = pe_r; ins_len = w_sz; ins_own = w_pid; end
      INS_WAIT_LO: begin ins_addr = lo_r; ins_len = w_sz; ins_own = w_pid; end
      default:     begin
        ins_addr = pe_r; ins_len = req_r.req_size; ins_own = req_r.process_id;
      end
    endcase
    pos = blk_cnt_r;
    for (int j = MAX_BLOCKS - 1; j >= 0; j--) begin
      if ((BCW'(j) < blk_cnt_r) && ({1'b0, ts_r[j]} >= ins_addr)) pos = BCW'(j);
    end
  end

  // table update: shift down on remove, shift up on insert
  always_comb begin
    ts_nxt = ts_r;
    tl_nxt = tl_r;
    to_nxt = to_r;
    blk_cnt_nxt = blk_cnt_r;
    if (cmd.rm_blk) begin
      for (int j = 0; j < MAX_BLOCKS - 1; j++) begin
        if (BCW'(j) >= k_r) begin
          ts_nxt[j] = ts_r[j+1];
          tl_nxt[j] = tl_r[j+1];
          to_nxt[j] = to_r[j+1];
        end
      end
      blk_cnt_nxt = blk_cnt_r - BCW'(1);
    end else if (cmd.ins) begin
      for (int j = 1; j < MAX_BLOCKS; j++) begin
        if (BCW'(j) > pos) begin
          ts_nxt[j] = ts_r[j-1];
          tl_nxt[j] = tl_r[j-1];
          to_nxt[j] = to_r[j-1];
        end
      end
      for (int j = 0; j < MAX_BLOCKS; j++) begin
        if (BCW'(j) == pos) begin
          ts_nxt[j] = ins_addr[AW-1:0];
          tl_nxt[j] = ins_len;
          to_nxt[j] = ins_own;
        end
      end
      blk_cnt_nxt = blk_cnt_r + BCW'(1);
    end
  end

  // wait queue: push at tail, remove with compaction
  always_comb begin
    wid_nxt  = wid_r;
    wpid_nxt = wpid_r;
    wsz_nxt  = wsz_r;
    wcnt_nxt = wcnt_r;
    if (cmd.wq_clr) begin
      wcnt_nxt = '0;
    end else if (cmd.push_wait) begin
      wid_nxt[wcnt_r[WW-1:0]]  = id_r;
      wpid_nxt[wcnt_r[WW-1:0]] = req_r.process_id;
      wsz_nxt[wcnt_r[WW-1:0]]  = req_r.req_size;
      wcnt_nxt = wcnt_r + WCW'(1);
    end else if (cmd.rm_wait) begin
      for (int j = 0; j < MAX_WAITING - 1; j++) begin
        if (WCW'(j) >= i_r) begin
          wid_nxt[j]  = wid_r[j+1];
          wpid_nxt[j] = wpid_r[j+1];
          wsz_nxt[j]  = wsz_r[j+1];
        end
      end
      wcnt_nxt = wcnt_r - WCW'(1);
    end
  end

  // scan registers
  always_comb begin
    k_nxt = k_r;
    if (cmd.latch || cmd.k_clr) k_nxt = '0;
    else if (cmd.k_inc)         k_nxt = k_r + BCW'(1);
    i_nxt = i_r;
    if (cmd.latch || cmd.i_clr) i_nxt = '0;
    else if (cmd.i_inc)         i_nxt = i_r + WCW'(1);
    pe_nxt = pe_r;
    if (cmd.latch || cmd.pe_clr) pe_nxt = '0;
    else if (cmd.pe_upd)         pe_nxt = rd_end;
    lo_nxt   = lo_r;
    room_nxt = room_r;
    hi       = sts.kp1_end ? mem_e : rs;
    if (cmd.lo_ld) lo_nxt = sts.k_zero ? '0 : rd_end;
    if (cmd.hi_ld) room_nxt = (hi > lo_r) ? (hi - lo_r) : '0;
    if (cmd.pack_adv) begin
      room_nxt = room_r - {1'b0, w_sz};
      lo_nxt   = lo_r + {1'b0, w_sz};
    end
  end

  // result register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      if (cmd.emit_final) begin
        out_nxt.request_id  = id_r;
        out_nxt.result_kind = fin_kind_r;
        out_nxt.placed_addr = '0;
        out_nxt.last        = 1'b1;
      end else begin
        out_nxt.request_id  = cmd.emit_wid ? w_id : id_r;
        out_nxt.result_kind = cmd.emit_kind;
        unique case (cmd.emit_addr)
          AS_PE:   out_nxt.placed_addr = pe_r[AW-1:0];
          AS_LO:   out_nxt.placed_addr = lo_r[AW-1:0];
          default: out_nxt.placed_addr = '0;
        endcase
        out_nxt.last = cmd.emit_last;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_r       <= MEM_SIZE_RST;
      ctr_r       <= '0;
      blk_cnt_r   <= '0;
      wcnt_r      <= '0;
      k_r         <= '0;
      i_r         <= '0;
      got_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) mem_r <= cfg_wdata;
      if (cmd.latch) ctr_r <= ctr_r + AW'(1);
      blk_cnt_r   <= blk_cnt_nxt;
      wcnt_r      <= wcnt_nxt;
      k_r         <= k_nxt;
      i_r         <= i_nxt;
      if (cmd.latch)        got_r <= 1'b0;
      else if (cmd.got_set) got_r <= 1'b1;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= in_data;
      id_r  <= ctr_r;
    end
    if (cmd.final_ld) fin_kind_r <= cmd.final_kind;
    pe_r   <= pe_nxt;
    lo_r   <= lo_nxt;
    room_r <= room_nxt;
    out_r  <= out_nxt;
    ts_r   <= ts_nxt;
    tl_r   <= tl_nxt;
    to_r   <= to_nxt;
    wid_r  <= wid_nxt;
    wpid_r <= wpid_nxt;
    wsz_r  <= wsz_nxt;
  end

endmodule

>>> hdl/ffa_ctrl.sv
// Controller state machine sequencing scans, inserts, removals and results.
module ffa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ffa_pkg::dp_sts_t sts,
  output ffa_pkg::dp_cmd_t cmd
);
  import ffa_pkg::*;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_DECODE;
      ST_DECODE: begin
        unique case (sts.cmd)
          CMD_ALLOC: state_nxt = (sts.size_bad || sts.tbl_full) ? ST_FINAL : ST_FF;
          CMD_FREE:  state_nxt = ST_F_SCAN;
          CMD_TERM:  state_nxt = sts.k_end ? ST_FINAL : ST_T_RMB;
          default:   state_nxt = ST_H_LOOP;
        endcase
      end
      ST_FF: begin
        if (!sts.k_end && !sts.fit_here) begin
          state_nxt = ST_FF;
        end else if (sts.k_end ? sts.tail_fit : 1'b1) begin
          state_nxt = (sts.cmd == CMD_ALLOC) ? ST_A_PLACE : ST_T_PLACE;
        end else if (sts.cmd == CMD_ALLOC) begin
          state_nxt = sts.wq_full ? ST_FINAL : ST_IDLE;
        end else begin
          state_nxt = ST_T_RETRY;
        end
      end
      ST_A_PLACE: if (sts.can_emit) state_nxt = ST_IDLE;
      ST_F_SCAN: begin
        if (sts.k_end)          state_nxt = ST_FINAL;
        else if (sts.start_hit) state_nxt = sts.own_hit ? ST_F_LO : ST_FINAL;
      end
      ST_F_LO:   state_nxt = ST_F_HI;
      ST_F_HI:   state_nxt = ST_F_PACK;
      ST_F_PACK: if (sts.i_end) state_nxt = ST_FINAL;
      ST_T_RMB:  if (sts.k_end) state_nxt = ST_T_WQ;
      ST_T_WQ:   if (sts.i_end) state_nxt = ST_T_RETRY;
      ST_T_RETRY: begin
        if (sts.i_end)          state_nxt = ST_FINAL;
        else if (!sts.tbl_full) state_nxt = ST_FF;
      end
      ST_T_PLACE: if (sts.can_emit) state_nxt = ST_T_RETRY;
      ST_H_LOOP:  if (sts.i_end) state_nxt = ST_FINAL;
      ST_FINAL:   if (sts.can_emit) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    cmd.ins_sel   = INS_REQ;
    cmd.emit_addr = AS_ZERO;
    cmd.rd_sel    = RD_K;
    cmd.emit_kind = K_AFAIL;
    cmd.final_kind = K_FAIL;
    unique case (state_r)
      ST_IDLE: cmd.latch = in_valid;
      ST_DECODE: begin
        unique case (sts.cmd)
          CMD_ALLOC: begin
            cmd.final_ld   = sts.size_bad || sts.tbl_full;
            cmd.final_kind = K_AFAIL;
          end
          CMD_TERM: begin
            cmd.final_ld   = sts.k_end;
            cmd.final_kind = K_FAIL;
          end
          default: cmd.final_ld = 1'b0;
        endcase
      end
      ST_FF: begin
        if (!sts.k_end && !sts.fit_here) begin
          cmd.pe_upd = 1'b1;
          cmd.k_inc  = 1'b1;
        end else if (sts.k_end && !sts.tail_fit) begin
          if (sts.cmd == CMD_ALLOC) begin
            cmd.push_wait  = !sts.wq_full;
            cmd.final_ld   = sts.wq_full;
            cmd.final_kind = K_AFAIL;
          end else begin
            cmd.i_inc = 1'b1;
          end
        end
      end
      ST_A_PLACE: begin
        cmd.ins       = sts.can_emit;
        cmd.ins_sel   = INS_REQ;
        cmd.emit      = sts.can_emit;
        cmd.emit_kind = K_PLACED;
        cmd.emit_addr = AS_PE;
        cmd.emit_last = 1'b1;
      end
      ST_F_SCAN: begin
        cmd.final_kind = K_FAIL;
        if (sts.k_end)          cmd.final_ld = 1'b1;
        else if (sts.start_hit) cmd.final_ld = !sts.own_hit;
        else                    cmd.k_inc = 1'b1;
      end
      ST_F_LO: begin
        cmd.rd_sel = RD_KM1;
        cmd.lo_ld  = 1'b1;
      end
      ST_F_HI: begin
        cmd.rd_sel = RD_KP1;
        cmd.hi_ld  = 1'b1;
        cmd.rm_blk = 1'b1;
      end
      ST_F_PACK: begin
        if (sts.i_end) begin
          cmd.final_ld   = 1'b1;
          cmd.final_kind = K_OK;
        end else if (!sts.tbl_full && sts.wfits) begin
          cmd.ins       = sts.can_emit;
          cmd.ins_sel   = INS_WAIT_LO;
          cmd.emit      = sts.can_emit;
          cmd.emit_wid  = 1'b1;
          cmd.emit_kind = K_PLACED;
          cmd.emit_addr = AS_LO;
          cmd.pack_adv  = sts.can_emit;
          cmd.rm_wait   = sts.can_emit;
        end else begin
          cmd.i_inc = 1'b1;
        end
      end
      ST_T_RMB: begin
        if (sts.k_end) begin
          cmd.i_clr = 1'b1;
        end else if (sts.own_hit) begin
          cmd.rm_blk  = 1'b1;
          cmd.got_set = 1'b1;
        end else begin
          cmd.k_inc = 1'b1;
        end
      end
      ST_T_WQ: begin
        if (sts.i_end) begin
          cmd.i_clr = 1'b1;
        end else if (sts.wpid_hit) begin
          cmd.emit      = sts.can_emit;
          cmd.emit_wid  = 1'b1;
          cmd.emit_kind = K_AFAIL;
          cmd.rm_wait   = sts.can_emit;
        end else begin
          cmd.i_inc = 1'b1;
        end
      end
      ST_T_RETRY: begin
        if (sts.i_end) begin
          cmd.final_ld   = 1'b1;
          cmd.final_kind = sts.got ? K_OK : K_FAIL;
        end else if (sts.tbl_full) begin
          cmd.i_inc = 1'b1;
        end else begin
          cmd.k_clr  = 1'b1;
          cmd.pe_clr = 1'b1;
        end
      end
      ST_T_PLACE: begin
        cmd.ins       = sts.can_emit;
        cmd.ins_sel   = INS_WAIT_PE;
        cmd.emit      = sts.can_emit;
        cmd.emit_wid  = 1'b1;
        cmd.emit_kind = K_PLACED;
        cmd.emit_addr = AS_PE;
        cmd.rm_wait   = sts.can_emit;
      end
      ST_H_LOOP: begin
        if (sts.i_end) begin
          cmd.wq_clr     = 1'b1;
          cmd.final_ld   = 1'b1;
          cmd.final_kind = K_HALT;
        end else begin
          cmd.emit      = sts.can_emit;
          cmd.emit_wid  = 1'b1;
          cmd.emit_kind = K_AFAIL;
          cmd.i_inc     = sts.can_emit;
        end
      end
      ST_FINAL: begin
        cmd.emit       = sts.can_emit;
        cmd.emit_final = 1'b1;
      end
      default: cmd.latch = 1'b0;
    endcase
  end

endmodule

>>> hdl/first_fit_allocator_with_wait_queue.sv
// Top level of the first-fit region allocator with a wait queue.
//
// Input channel (in_valid / in_stall / in_data): one command transaction per
// accepted item: allocate, free block, terminate process or halt. Each
// command gets a 16-bit request_id from a wrapping counter.
// Output channel (out_valid / out_stall / out_data): result transactions.
// Results for waiters come first in queue order; the command's own result
// comes last with last set. An allocate that has to wait produces nothing
// until a later free, terminate or halt places or fails it.
// Config: cfg_we / cfg_wdata writes mem_size; write only while idle.
// Timing: one command at a time; in_stall is high from acceptance until the
// final result is loaded into the output register, or until an allocate is
// queued to wait. Each table scan steps one entry per cycle through the
// shared table read port. Stalls on out_stall hold the result register and
// pause the sequencer only when a new result must be emitted.
// Reset (rst_n low, synchronous): table and queue empty, counter zero,
// mem_size 65535, no result pending.
module first_fit_allocator_with_wait_queue #(
  parameter int MAX_BLOCKS  = ffa_pkg::MAX_BLOCKS_DEF,
  parameter int MAX_WAITING = ffa_pkg::MAX_WAITING_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ffa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ffa_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);
  import ffa_pkg::*;

  dp_cmd_t dp_cmd;  // controller -> datapath
  dp_sts_t dp_sts;  // datapath -> controller

  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  ffa_dp #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .MAX_WAITING (MAX_WAITING)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> hdl/ffa_chk.sv
// Port-level assertions for the allocator, bound to the top level.
module ffa_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ffa_pkg::out_item_t out_data
);
  import ffa_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one command at a time: busy right after a transaction is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted back to back");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.result_kind <= K_HALT)
    else $error("bad result kind");

  a_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind != K_PLACED |-> out_data.placed_addr == '0)
    else $error("address on non-placed result");

  a_halt_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == K_HALT |-> out_data.last)
    else $error("halt done without last");

endmodule

bind first_fit_allocator_with_wait_queue ffa_chk u_ffa_chk (.*);
